### design/bdut_pkg.sv
// Shared constants and types for the BDD unique-table insert unit.
// No dependencies; compiled first.
`default_nettype none

package bdut_pkg;

    localparam int NODE_COUNT_DEF    = 4096;
    localparam int HASH_BITS_MAX_DEF = 12;
    localparam int VAR_BITS_DEF      = 10;

    localparam int          CFG_W           = 4;
    localparam logic [3:0]  HASH_BITS_RESET = 4'd12;
    localparam logic [4:0]  HASH_BITS_MIN   = 5'd2;
    localparam logic [31:0] HASH_XOR        = 32'h5555_5555;

    // nodes 0 and 1 are the terminals
    localparam int FREE_FIRST = 2;

    typedef struct packed {
        logic valid;
        logic eq;
    } req_ctl_t;

endpackage

`default_nettype wire

### design/bdd_unique_table_insert_unit.sv
// BDD unique table find-or-create: the back end takes one request at a time, with one node
// memory read per chain step. Equal children go straight from accept to result; an empty
// bucket miss reads the bucket head, then allocates; a hit walks the chain to the match; a
// miss walks the whole chain, then allocates. The back end is idle again before it takes the
// next request; a two-entry queue feeds it. After reset, full is high while buckets clear.
// Top level; depends on bdut_pkg, bdut_front, bdut_back, bdut_ram.
`default_nettype none

module bdd_unique_table_insert_unit #(
    parameter int NODE_COUNT    = bdut_pkg::NODE_COUNT_DEF,
    parameter int HASH_BITS_MAX = bdut_pkg::HASH_BITS_MAX_DEF,
    parameter int VAR_BITS      = bdut_pkg::VAR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          hash_bits_in_use_we,
    input  logic [bdut_pkg::CFG_W-1:0]    hash_bits_in_use,
    input  logic                          push,
    output logic                          full,
    input  logic [VAR_BITS-1:0]           var_id,
    input  logic [$clog2(NODE_COUNT)-1:0] low_child,
    input  logic [$clog2(NODE_COUNT)-1:0] high_child,
    output logic                          empty,
    input  logic                          pop,
    output logic [$clog2(NODE_COUNT)-1:0] node_index,
    output logic                          created,
    output logic                          out_of_memory
);

    import bdut_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);

    req_ctl_t                q_ctl;
    logic [VAR_BITS-1:0]     q_var;
    logic [IDX_W-1:0]        q_lo;
    logic [IDX_W-1:0]        q_hi;
    logic [HASH_BITS_MAX-1:0] q_bucket;
    logic                    q_pop;
    logic                    clearing;

    bdut_front #(
        .NODE_COUNT    (NODE_COUNT),
        .HASH_BITS_MAX (HASH_BITS_MAX),
        .VAR_BITS      (VAR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (hash_bits_in_use_we),
        .cfg_data   (hash_bits_in_use),
        .hold       (clearing),
        .push       (push),
        .full       (full),
        .var_id     (var_id),
        .low_child  (low_child),
        .high_child (high_child),
        .q_ctl      (q_ctl),
        .q_var      (q_var),
        .q_lo       (q_lo),
        .q_hi       (q_hi),
        .q_bucket   (q_bucket),
        .q_pop      (q_pop)
    );

    bdut_back #(
        .NODE_COUNT    (NODE_COUNT),
        .HASH_BITS_MAX (HASH_BITS_MAX),
        .VAR_BITS      (VAR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clearing      (clearing),
        .q_ctl         (q_ctl),
        .q_var         (q_var),
        .q_lo          (q_lo),
        .q_hi          (q_hi),
        .q_bucket      (q_bucket),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .node_index    (node_index),
        .created       (created),
        .out_of_memory (out_of_memory)
    );

endmodule

`default_nettype wire

### design/bdut_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module bdut_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### design/bdut_front.sv
// Front end: config register, triple hash, bucket select and a two-entry request queue.
// Depends on bdut_pkg.
`default_nettype none

module bdut_front #(
    parameter int NODE_COUNT    = bdut_pkg::NODE_COUNT_DEF,
    parameter int HASH_BITS_MAX = bdut_pkg::HASH_BITS_MAX_DEF,
    parameter int VAR_BITS      = bdut_pkg::VAR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdut_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          hold,
    input  logic                          push,
    output logic                          full,
    input  logic [VAR_BITS-1:0]           var_id,
    input  logic [$clog2(NODE_COUNT)-1:0] low_child,
    input  logic [$clog2(NODE_COUNT)-1:0] high_child,
    output bdut_pkg::req_ctl_t            q_ctl,
    output logic [VAR_BITS-1:0]           q_var,
    output logic [$clog2(NODE_COUNT)-1:0] q_lo,
    output logic [$clog2(NODE_COUNT)-1:0] q_hi,
    output logic [HASH_BITS_MAX-1:0]      q_bucket,
    input  logic                          q_pop
);

    import bdut_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int HB    = HASH_BITS_MAX;

    logic [CFG_W-1:0] hash_bits_reg;

    logic [VAR_BITS-1:0] ent_var_reg [2];
    logic [IDX_W-1:0]    ent_lo_reg  [2];
    logic [IDX_W-1:0]    ent_hi_reg  [2];
    logic [HB-1:0]       ent_bkt_reg [2];
    logic                ent_eq_reg  [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    logic          do_push;
    logic [HB-1:0] bucket;

    always_comb
    begin
        logic [4:0]  eff;
        logic [4:0]  s1;
        logic [4:0]  s2;
        logic [31:0] j;
        logic [31:0] hi32;
        logic [31:0] sum;
        logic [31:0] mask;
        eff = {1'b0, hash_bits_reg};
        if (eff < HASH_BITS_MIN)
        begin
            eff = HASH_BITS_MIN;
        end
        else if (eff > 5'(HB))
        begin
            eff = 5'(HB);
        end
        s1   = eff >> 1;
        s2   = eff >> 2;
        j    = 32'(low_child) ^ HASH_XOR;
        hi32 = 32'(high_child);
        sum  = 32'(var_id) + (j << s1) + (j >> s1) + (hi32 << s2) + (hi32 >> s2);
        mask = (32'd1 << eff) - 32'd1;
        bucket = sum[HB-1:0] & mask[HB-1:0];
    end

    assign full    = (cnt_reg == 2'd2) || hold;
    assign do_push = push && !full;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_bits_reg <= HASH_BITS_RESET;
            wr_ptr_reg    <= 1'b0;
            rd_ptr_reg    <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                hash_bits_reg <= cfg_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_var_reg[wr_ptr_reg] <= var_id;
            ent_lo_reg[wr_ptr_reg]  <= low_child;
            ent_hi_reg[wr_ptr_reg]  <= high_child;
            ent_bkt_reg[wr_ptr_reg] <= bucket;
            ent_eq_reg[wr_ptr_reg]  <= (low_child == high_child);
        end
    end

    assign q_ctl.valid = (cnt_reg != 2'd0);
    assign q_ctl.eq    = ent_eq_reg[rd_ptr_reg];
    assign q_var       = ent_var_reg[rd_ptr_reg];
    assign q_lo        = ent_lo_reg[rd_ptr_reg];
    assign q_hi        = ent_hi_reg[rd_ptr_reg];
    assign q_bucket    = ent_bkt_reg[rd_ptr_reg];

endmodule

`default_nettype wire

### design/bdut_back.sv
// Back end: bucket-head and node memories, chain walk, allocation, result register.
// Depends on bdut_pkg and bdut_ram.
`default_nettype none

module bdut_back #(
    parameter int NODE_COUNT    = bdut_pkg::NODE_COUNT_DEF,
    parameter int HASH_BITS_MAX = bdut_pkg::HASH_BITS_MAX_DEF,
    parameter int VAR_BITS      = bdut_pkg::VAR_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          clearing,
    input  bdut_pkg::req_ctl_t            q_ctl,
    input  logic [VAR_BITS-1:0]           q_var,
    input  logic [$clog2(NODE_COUNT)-1:0] q_lo,
    input  logic [$clog2(NODE_COUNT)-1:0] q_hi,
    input  logic [HASH_BITS_MAX-1:0]      q_bucket,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [$clog2(NODE_COUNT)-1:0] node_index,
    output logic                          created,
    output logic                          out_of_memory
);

    import bdut_pkg::*;

    localparam int IDX_W   = $clog2(NODE_COUNT);
    localparam int HB      = HASH_BITS_MAX;
    localparam int BUCKETS = 1 << HB;
    localparam int NODE_W  = VAR_BITS + 3 * IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_ALLOC = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    logic          clr_busy_reg, clr_busy_next;
    logic [HB-1:0] clr_cnt_reg, clr_cnt_next;

    logic [IDX_W-1:0] free_reg, free_next;

    logic [VAR_BITS-1:0] var_reg, var_next;
    logic [IDX_W-1:0]    lo_reg, lo_next;
    logic [IDX_W-1:0]    hi_reg, hi_next;
    logic [HB-1:0]       bkt_reg, bkt_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;

    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic             res_created_reg, res_created_next;
    logic             res_oom_reg, res_oom_next;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_created_reg;
    logic             out_oom_reg;
    logic             out_load;

    logic             bkt_we;
    logic [HB-1:0]    bkt_waddr;
    logic [IDX_W-1:0] bkt_wdata;
    logic [IDX_W-1:0] bkt_rdata;

    logic              nd_we;
    logic [IDX_W-1:0]  nd_raddr;
    logic [NODE_W-1:0] nd_rdata;

    logic [VAR_BITS-1:0] nd_var;
    logic [IDX_W-1:0]    nd_low;
    logic [IDX_W-1:0]    nd_high;
    logic [IDX_W-1:0]    nd_chain;
    logic                alloc_ok;
    logic                match;

    assign {nd_var, nd_low, nd_high, nd_chain} = nd_rdata;

    assign alloc_ok = (free_reg != '0);
    assign match    = (nd_var == var_reg) && (nd_low == lo_reg) && (nd_high == hi_reg);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || pop);
    assign q_pop    = (state_reg == S_IDLE) && !clr_busy_reg && q_ctl.valid;
    assign clearing = clr_busy_reg;

    assign bkt_we    = clr_busy_reg || ((state_reg == S_ALLOC) && alloc_ok);
    assign bkt_waddr = clr_busy_reg ? clr_cnt_reg : bkt_reg;
    assign bkt_wdata = clr_busy_reg ? '0 : free_reg;
    assign nd_we     = (state_reg == S_ALLOC) && alloc_ok;
    assign nd_raddr  = (state_reg == S_HEAD) ? bkt_rdata : nd_chain;

    bdut_ram #(
        .WIDTH (IDX_W),
        .DEPTH (BUCKETS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .raddr (q_bucket),
        .rdata (bkt_rdata)
    );

    bdut_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .clk   (clk),
        .we    (nd_we),
        .waddr (free_reg),
        .wdata ({var_reg, lo_reg, hi_reg, head_reg}),
        .raddr (nd_raddr),
        .rdata (nd_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        clr_busy_next    = clr_busy_reg;
        clr_cnt_next     = clr_cnt_reg;
        free_next        = free_reg;
        var_next         = var_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        bkt_next         = bkt_reg;
        head_next        = head_reg;
        cur_next         = cur_reg;
        res_idx_next     = res_idx_reg;
        res_created_next = res_created_reg;
        res_oom_next     = res_oom_reg;

        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == HB'(BUCKETS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    var_next = q_var;
                    lo_next  = q_lo;
                    hi_next  = q_hi;
                    bkt_next = q_bucket;
                    if (q_ctl.eq)
                    begin
                        res_idx_next     = q_lo;
                        res_created_next = 1'b0;
                        res_oom_next     = 1'b0;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD:
            begin
                head_next = bkt_rdata;
                cur_next  = bkt_rdata;
                state_next = (bkt_rdata == '0) ? S_ALLOC : S_CMP;
            end
            S_CMP:
            begin
                if (match)
                begin
                    res_idx_next     = cur_reg;
                    res_created_next = 1'b0;
                    res_oom_next     = 1'b0;
                    state_next       = S_DONE;
                end
                else
                begin
                    cur_next   = nd_chain;
                    state_next = (nd_chain == '0) ? S_ALLOC : S_CMP;
                end
            end
            S_ALLOC:
            begin
                if (alloc_ok)
                begin
                    res_idx_next     = free_reg;
                    res_created_next = 1'b1;
                    res_oom_next     = 1'b0;
                    free_next        = (free_reg == IDX_W'(NODE_COUNT - 1)) ? '0 :
                                       free_reg + 1'b1;
                end
                else
                begin
                    res_idx_next     = '0;
                    res_created_next = 1'b0;
                    res_oom_next     = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            free_reg      <= IDX_W'(FREE_FIRST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        var_reg         <= var_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        bkt_reg         <= bkt_next;
        head_reg        <= head_next;
        cur_reg         <= cur_next;
        res_idx_reg     <= res_idx_next;
        res_created_reg <= res_created_next;
        res_oom_reg     <= res_oom_next;
        if (out_load)
        begin
            out_idx_reg     <= res_idx_reg;
            out_created_reg <= res_created_reg;
            out_oom_reg     <= res_oom_reg;
        end
    end

    assign empty         = !out_valid_reg;
    assign node_index    = out_idx_reg;
    assign created       = out_created_reg;
    assign out_of_memory = out_oom_reg;

endmodule

`default_nettype wire

### design/bdut_checker.sv
// Port-level assertions for the unique table insert unit, bound to the top level.
// Depends on bdut_pkg and bdd_unique_table_insert_unit.
`default_nettype none

module bdut_checker #(
    parameter int NODE_COUNT = bdut_pkg::NODE_COUNT_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          empty,
    input wire logic                          pop,
    input wire logic [$clog2(NODE_COUNT)-1:0] node_index,
    input wire logic                          created,
    input wire logic                          out_of_memory
);

    import bdut_pkg::*;

    localparam int IDX_W = $clog2(NODE_COUNT);

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(created && out_of_memory))
        else $error("created and out_of_memory both set");

    a_oom_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_of_memory) |-> (node_index == '0))
        else $error("out_of_memory result with nonzero node_index");

    a_created_not_terminal: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && created) |-> (node_index >= IDX_W'(FREE_FIRST)))
        else $error("created node is a terminal");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(node_index) && $stable(created)
                              && $stable(out_of_memory)))
        else $error("stalled result changed");

endmodule

bind bdd_unique_table_insert_unit bdut_checker #(
    .NODE_COUNT (NODE_COUNT)
) u_bdut_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .node_index    (node_index),
    .created       (created),
    .out_of_memory (out_of_memory)
);

`default_nettype wire

### bench/tb_bdd_unique_table_insert_unit.sv
// Testbench for bdd_unique_table_insert_unit: directed table, then random find-or-create
// traffic checked against an in-bench copy of the unique table.
// Depends on bdut_pkg and the unit under test.
`timescale 1ns / 1ps

module tb_bdd_unique_table_insert_unit;

    import bdut_pkg::*;

    localparam int IDX_W           = $clog2(NODE_COUNT_DEF);
    localparam int VAR_W           = VAR_BITS_DEF;
    localparam int BUCKETS         = 1 << HASH_BITS_MAX_DEF;
    localparam int IDLE_PCT        = 18;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 45;
    localparam int SETTLE_CYCLES   = 2;
    localparam int TAIL_CYCLES     = 16;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int NUM_ROWS        = 28;

    typedef struct packed {
        logic [VAR_W-1:0] v;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } node_key_t;

    typedef struct packed {
        logic [IDX_W-1:0] node;
        logic             created;
        logic             oom;
    } node_result_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic [3:0]   bits;
        node_key_t    key;
        logic         typed;
        node_result_t want;
    } dir_row_t;

    localparam logic [3:0] PHASE_BITS [10] = '{4'd12, 4'd2, 4'd0, 4'd7, 4'd15,
                                               4'd1, 4'd13, 4'd5, 4'd3, 4'd10};

    logic             clk = 1'b0;
    logic             rst_n;
    logic             hash_bits_in_use_we;
    logic [CFG_W-1:0] hash_bits_in_use;
    logic             push;
    logic             full;
    logic [VAR_W-1:0] var_id;
    logic [IDX_W-1:0] low_child;
    logic [IDX_W-1:0] high_child;
    logic             empty;
    logic             pop;
    logic [IDX_W-1:0] node_index;
    logic             created;
    logic             out_of_memory;

    // in-bench copy of the unique table
    logic [VAR_W-1:0] node_var   [NODE_COUNT_DEF];
    logic [IDX_W-1:0] node_low   [NODE_COUNT_DEF];
    logic [IDX_W-1:0] node_high  [NODE_COUNT_DEF];
    logic [IDX_W-1:0] node_chain [NODE_COUNT_DEF];
    logic [IDX_W-1:0] bucket_head [BUCKETS];
    logic [IDX_W-1:0] free_head;
    logic [3:0]       cur_hash_bits;

    node_result_t expected_results [$];
    node_key_t    known_keys [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    logic         calm = 1'b0;
    logic         hold_req = 1'b0;

    dir_row_t dir_rows [NUM_ROWS] = '{
        '{ROW_ITEM, 4'd0, '{10'd0, 12'd0, 12'd1}, 1'b1, '{12'd2, 1'b1, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd0, 12'd0, 12'd1}, 1'b1, '{12'd2, 1'b0, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd1023, 12'd4095, 12'd4095}, 1'b1, '{12'd4095, 1'b0, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd0, 12'd0, 12'd0}, 1'b1, '{12'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd1023, 12'd4095, 12'd0}, 1'b1, '{12'd3, 1'b1, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd1023, 12'd0, 12'd4095}, 1'b1, '{12'd4, 1'b1, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd1023, 12'd4095, 12'd0}, 1'b1, '{12'd3, 1'b0, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd682, 12'd2730, 12'd1365}, 1'b1, '{12'd5, 1'b1, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd341, 12'd1365, 12'd2730}, 1'b1, '{12'd6, 1'b1, 1'b0}},
        '{ROW_ITEM, 4'd0, '{10'd5, 12'd1, 12'd0}, 1'b1, '{12'd7, 1'b1, 1'b0}},
        '{ROW_CFG, 4'd0, '0, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd0, 12'd0, 12'd1}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd7, 12'd100, 12'd200}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd7, 12'd100, 12'd200}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd8, 12'd100, 12'd200}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd9, 12'd100, 12'd200}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd7, 12'd100, 12'd200}, 1'b0, '0},
        '{ROW_CFG, 4'd15, '0, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd0, 12'd0, 12'd1}, 1'b0, '0},
        '{ROW_CFG, 4'd1, '0, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd9, 12'd100, 12'd200}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd1, 12'd2, 12'd3}, 1'b0, '0},
        '{ROW_CFG, 4'd13, '0, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd682, 12'd2730, 12'd1365}, 1'b0, '0},
        '{ROW_CFG, HASH_BITS_RESET, '0, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd1023, 12'd4095, 12'd0}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd3, 12'd1, 12'd0}, 1'b0, '0},
        '{ROW_ITEM, 4'd0, '{10'd3, 12'd1, 12'd0}, 1'b0, '0}
    };

    bdd_unique_table_insert_unit i_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .hash_bits_in_use_we (hash_bits_in_use_we),
        .hash_bits_in_use    (hash_bits_in_use),
        .push                (push),
        .full                (full),
        .var_id              (var_id),
        .low_child           (low_child),
        .high_child          (high_child),
        .empty               (empty),
        .pop                 (pop),
        .node_index          (node_index),
        .created             (created),
        .out_of_memory       (out_of_memory)
    );

    always #2 clk = ~clk;

    function automatic node_result_t find_or_create(node_key_t k);
        node_result_t     r;
        logic [31:0]      j;
        logic [31:0]      hi32;
        logic [31:0]      sum;
        int unsigned      h;
        int unsigned      steps;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] fresh;
        r = '0;
        if (k.lo == k.hi)
        begin
            r.node = k.lo;
            return r;
        end
        h = cur_hash_bits;
        if (h < HASH_BITS_MIN)
            h = HASH_BITS_MIN;
        if (h > HASH_BITS_MAX_DEF)
            h = HASH_BITS_MAX_DEF;
        j    = {{(32-IDX_W){1'b0}}, k.lo} ^ HASH_XOR;
        hi32 = {{(32-IDX_W){1'b0}}, k.hi};
        sum  = {{(32-VAR_W){1'b0}}, k.v} + (j << (h >> 1)) + (j >> (h >> 1))
               + (hi32 << (h >> 2)) + (hi32 >> (h >> 2));
        sum  = sum & ((32'd1 << h) - 32'd1);
        b    = sum[IDX_W-1:0];
        cur   = bucket_head[b];
        steps = 0;
        while (cur != '0 && steps < NODE_COUNT_DEF)
        begin
            if (node_var[cur] == k.v && node_low[cur] == k.lo && node_high[cur] == k.hi)
            begin
                r.node = cur;
                return r;
            end
            cur = node_chain[cur];
            steps++;
        end
        fresh = free_head;
        if (fresh == '0)
        begin
            r.oom = 1'b1;
            return r;
        end
        free_head         = node_low[fresh];
        node_var[fresh]   = k.v;
        node_low[fresh]   = k.lo;
        node_high[fresh]  = k.hi;
        node_chain[fresh] = bucket_head[b];
        bucket_head[b]    = fresh;
        r.node    = fresh;
        r.created = 1'b1;
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] pick_child();
        if ($urandom_range(3) == 0)
            return IDX_W'($urandom_range(1));
        return IDX_W'($urandom_range(NODE_COUNT_DEF - 1));
    endfunction

    function automatic node_key_t fresh_key();
        node_key_t k;
        k.v  = VAR_W'($urandom_range((1 << VAR_W) - 1));
        k.lo = pick_child();
        do
            k.hi = pick_child();
        while (k.hi == k.lo);
        return k;
    endfunction

    task automatic send_item(node_key_t k, logic typed, node_result_t want);
        node_result_t r;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push       <= 1'b1;
        var_id     <= k.v;
        low_child  <= k.lo;
        high_child <= k.hi;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = find_or_create(k);
        expected_results.push_back(typed ? want : r);
        if (k.lo != k.hi)
            known_keys.push_back(k);
        @(negedge clk);
    endtask

    task automatic send_random();
        node_key_t   k;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            k.v  = VAR_W'($urandom_range((1 << VAR_W) - 1));
            k.lo = pick_child();
            k.hi = k.lo;
        end
        else if (pick < 55 && known_keys.size() > 0)
            k = known_keys[$urandom_range(known_keys.size() - 1)];
        else
            k = fresh_key();
        send_item(k, 1'b0, '0);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_hash_bits(logic [3:0] val);
        hash_bits_in_use_we <= 1'b1;
        hash_bits_in_use    <= val;
        @(negedge clk);
        hash_bits_in_use_we <= 1'b0;
        cur_hash_bits = val;
    endtask

    // stimulus
    initial
    begin
        rst_n               = 1'b0;
        push                = 1'b0;
        var_id              = '0;
        low_child           = '0;
        high_child          = '0;
        hash_bits_in_use_we = 1'b0;
        hash_bits_in_use    = HASH_BITS_RESET;
        for (int n = 0; n < NODE_COUNT_DEF; n++)
        begin
            node_var[n]   = '0;
            node_low[n]   = IDX_W'(n + 1);
            node_high[n]  = '0;
            node_chain[n] = '0;
        end
        for (int n = 0; n < BUCKETS; n++)
            bucket_head[n] = '0;
        free_head     = IDX_W'(FREE_FIRST);
        cur_hash_bits = HASH_BITS_RESET;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                settle();
                write_hash_bits(dir_rows[i].bits);
            end
            else
                send_item(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
        end

        foreach (PHASE_BITS[p])
        begin
            settle();
            write_hash_bits(PHASE_BITS[p]);
            calm = (p == 3);
            if (p == 1)
                hold_req = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random();
        end
        calm = 1'b0;

        // back to full hash width, then a narrow table
        settle();
        write_hash_bits(HASH_BITS_RESET);
        repeat (30) send_random();
        settle();
        write_hash_bits(4'd4);
        repeat (20) send_random();

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // result side: random pop, one long hold-off on request
    initial
    begin
        int hold_left;
        pop       = 1'b0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        node_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transfer: node_index %0d", node_index);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (node_index !== want.node)
                begin
                    $error("node_index: expected %0d, got %0d", want.node, node_index);
                    mismatches++;
                end
                if (created !== want.created)
                begin
                    $error("created: expected %0d, got %0d", want.created, created);
                    mismatches++;
                end
                if (out_of_memory !== want.oom)
                begin
                    $error("out_of_memory: expected %0d, got %0d", want.oom, out_of_memory);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
